/* rtl/tme_pkg.sv */
// Package for the text-to-Morse unit encoder: widths, descriptor types
// and the character-to-Morse code table. No dependencies.

package tme_pkg;

    // Field widths
    localparam int CHAR_W = 8;
    localparam int CODE_W = 7;   // longest pattern has seven elements
    localparam int LEN_W  = 3;
    localparam int GAP_W  = 4;   // up to 1 + 3 + 4 off units
    localparam int ON_W   = 2;   // a dah is three on units

    // Timing in units
    localparam int CHAR_GAP_UNITS = 3;
    localparam int END_GAP_UNITS  = 4;
    localparam int SPACE_UNITS    = 1;
    localparam int DIT_UNITS      = 1;
    localparam int DAH_UNITS      = 3;

    localparam logic [CHAR_W-1:0] ASCII_SPACE = 8'h20;

    // Descriptor queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Table entry: element count and dah flags, element 0 in the MSB
    typedef struct packed {
        logic              hit;
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] dah;
    } tme_code_t;

    // One classified character as handed to the back end
    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] dah;
        logic [GAP_W-1:0]  gap;
    } tme_desc_t;

    function automatic tme_code_t code_lookup(input logic [CHAR_W-1:0] ch);
        tme_code_t c;
        c.hit = 1'b1;
        case (ch)
            8'h61: begin c.len = 3'd2; c.dah = 7'b0100000; end // a
            8'h62: begin c.len = 3'd4; c.dah = 7'b1000000; end // b
            8'h63: begin c.len = 3'd4; c.dah = 7'b1010000; end // c
            8'h64: begin c.len = 3'd3; c.dah = 7'b1000000; end // d
            8'h65: begin c.len = 3'd1; c.dah = 7'b0000000; end // e
            8'h66: begin c.len = 3'd4; c.dah = 7'b0010000; end // f
            8'h67: begin c.len = 3'd3; c.dah = 7'b1100000; end // g
            8'h68: begin c.len = 3'd4; c.dah = 7'b0000000; end // h
            8'h69: begin c.len = 3'd2; c.dah = 7'b0000000; end // i
            8'h6a: begin c.len = 3'd4; c.dah = 7'b0111000; end // j
            8'h6b: begin c.len = 3'd3; c.dah = 7'b1010000; end // k
            8'h6c: begin c.len = 3'd4; c.dah = 7'b0100000; end // l
            8'h6d: begin c.len = 3'd2; c.dah = 7'b1100000; end // m
            8'h6e: begin c.len = 3'd2; c.dah = 7'b1000000; end // n
            8'h6f: begin c.len = 3'd3; c.dah = 7'b1110000; end // o
            8'h70: begin c.len = 3'd4; c.dah = 7'b0110000; end // p
            8'h71: begin c.len = 3'd4; c.dah = 7'b1101000; end // q
            8'h72: begin c.len = 3'd3; c.dah = 7'b0100000; end // r
            8'h73: begin c.len = 3'd3; c.dah = 7'b0000000; end // s
            8'h74: begin c.len = 3'd1; c.dah = 7'b1000000; end // t
            8'h75: begin c.len = 3'd3; c.dah = 7'b0010000; end // u
            8'h76: begin c.len = 3'd4; c.dah = 7'b0001000; end // v
            8'h77: begin c.len = 3'd3; c.dah = 7'b0110000; end // w
            8'h78: begin c.len = 3'd4; c.dah = 7'b1001000; end // x
            8'h79: begin c.len = 3'd4; c.dah = 7'b1011000; end // y
            8'h7a: begin c.len = 3'd4; c.dah = 7'b1100000; end // z
            8'h30: begin c.len = 3'd5; c.dah = 7'b1111100; end // 0
            8'h31: begin c.len = 3'd5; c.dah = 7'b0111100; end // 1
            8'h32: begin c.len = 3'd5; c.dah = 7'b0011100; end // 2
            8'h33: begin c.len = 3'd5; c.dah = 7'b0001100; end // 3
            8'h34: begin c.len = 3'd5; c.dah = 7'b0000100; end // 4
            8'h35: begin c.len = 3'd5; c.dah = 7'b0000000; end // 5
            8'h36: begin c.len = 3'd5; c.dah = 7'b1000000; end // 6
            8'h37: begin c.len = 3'd5; c.dah = 7'b1100000; end // 7
            8'h38: begin c.len = 3'd5; c.dah = 7'b1110000; end // 8
            8'h39: begin c.len = 3'd5; c.dah = 7'b1111000; end // 9
            8'h2e: begin c.len = 3'd6; c.dah = 7'b0101010; end // period
            8'h2c: begin c.len = 3'd6; c.dah = 7'b1100110; end // comma
            8'h3f: begin c.len = 3'd6; c.dah = 7'b0011000; end // question mark
            8'h27: begin c.len = 3'd6; c.dah = 7'b0111100; end // apostrophe
            8'h21: begin c.len = 3'd6; c.dah = 7'b1010110; end // exclamation
            8'h2f: begin c.len = 3'd5; c.dah = 7'b1001000; end // slash
            8'h28: begin c.len = 3'd5; c.dah = 7'b1011000; end // open paren
            8'h29: begin c.len = 3'd6; c.dah = 7'b1011010; end // close paren
            8'h26: begin c.len = 3'd5; c.dah = 7'b0100000; end // ampersand
            8'h3a: begin c.len = 3'd6; c.dah = 7'b1110000; end // colon
            8'h3b: begin c.len = 3'd6; c.dah = 7'b1010100; end // semicolon
            8'h3d: begin c.len = 3'd5; c.dah = 7'b1000100; end // equals
            8'h2b: begin c.len = 3'd5; c.dah = 7'b0101000; end // plus
            8'h2d: begin c.len = 3'd6; c.dah = 7'b1000010; end // hyphen
            8'h5f: begin c.len = 3'd6; c.dah = 7'b0011010; end // underscore
            8'h22: begin c.len = 3'd6; c.dah = 7'b0100100; end // double quote
            8'h24: begin c.len = 3'd7; c.dah = 7'b0001001; end // dollar
            8'h40: begin c.len = 3'd6; c.dah = 7'b0110100; end // at sign
            default:
            begin
                c.hit = 1'b0;
                c.len = '0;
                c.dah = '0;
            end
        endcase
        return c;
    endfunction

endpackage

/* rtl/tme_if.sv */
// Channel interfaces of the text-to-Morse unit encoder.
// Depends on tme_pkg for the character width.

interface tme_char_if;
    logic                      valid;
    logic                      ready;
    logic [tme_pkg::CHAR_W-1:0] char_code;
    logic                      message_end;

    modport source (output valid, output char_code, output message_end, input ready);
    modport sink   (input valid, input char_code, input message_end, output ready);
endinterface

interface tme_unit_if;
    logic valid;
    logic ready;
    logic key_on;
    logic run_last;

    modport source (output valid, output key_on, output run_last, input ready);
    modport sink   (input valid, input key_on, input run_last, output ready);
endinterface

/* rtl/tme_front.sv */
// Front end: accepts characters, looks up the Morse pattern and builds
// a descriptor for the queue. Depends on tme_pkg and tme_if.

module tme_front (
    tme_char_if.sink              char_in,
    input  logic                  q_full,
    output logic                  q_push,
    output tme_pkg::tme_desc_t    q_desc
);

    tme_pkg::tme_code_t         code;
    logic                       is_space;
    logic [tme_pkg::GAP_W-1:0]  gap;

    // Take a character whenever the queue has room
    assign char_in.ready = !q_full;
    assign q_push        = char_in.valid && !q_full;

    // Classify the character
    assign code     = tme_pkg::code_lookup(char_in.char_code);
    assign is_space = (char_in.char_code == tme_pkg::ASCII_SPACE);

    // Trailing off units: space unit, character gap, optional message gap
    always_comb
    begin
        gap = tme_pkg::GAP_W'(tme_pkg::CHAR_GAP_UNITS);
        if (is_space)
        begin
            gap = gap + tme_pkg::GAP_W'(tme_pkg::SPACE_UNITS);
        end
        if (char_in.message_end)
        begin
            gap = gap + tme_pkg::GAP_W'(tme_pkg::END_GAP_UNITS);
        end
    end

    // Unknown bytes carry no elements, only the gap
    assign q_desc.len = code.hit ? code.len : '0;
    assign q_desc.dah = code.dah;
    assign q_desc.gap = gap;

endmodule

/* rtl/tme_queue.sv */
// Short descriptor queue between the front and back ends.
// Depends on tme_pkg for the descriptor type and queue depth.

module tme_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  tme_pkg::tme_desc_t din,
    output logic               full,
    input  logic               pop,
    output logic               valid,
    output tme_pkg::tme_desc_t dout
);

    tme_pkg::tme_desc_t              slot_reg [tme_pkg::QUEUE_DEPTH];
    logic [tme_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [tme_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [tme_pkg::QUEUE_CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == tme_pkg::QUEUE_CNT_W'(tme_pkg::QUEUE_DEPTH));
    assign valid = (count_reg != '0);
    assign dout  = slot_reg[rd_ptr_reg];

    // Advance pointers with wrap at the queue depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == tme_pkg::QUEUE_PTR_W'(tme_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == tme_pkg::QUEUE_PTR_W'(tme_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Hold pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed descriptors
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("descriptor pushed into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> valid)
        else $error("descriptor popped from empty queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= tme_pkg::QUEUE_CNT_W'(tme_pkg::QUEUE_DEPTH))
        else $error("queue count above depth");

endmodule

/* rtl/tme_back.sv */
// Back end: plays one descriptor out as key units, one unit per cycle
// while unit_out takes them, into an output register. Depends on tme_pkg and tme_if.

module tme_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  tme_pkg::tme_desc_t q_desc,
    output logic               q_pop,
    tme_unit_if.source         unit_out
);

    typedef enum logic [1:0] {
        PH_ON,
        PH_SEP,
        PH_GAP
    } phase_t;

    logic                         busy_reg, busy_next;
    phase_t                       phase_reg, phase_next;
    logic [tme_pkg::ON_W-1:0]     on_left_reg, on_left_next;
    logic [tme_pkg::LEN_W-1:0]    idx_reg, idx_next;
    logic [tme_pkg::LEN_W-1:0]    len_reg, len_next;
    logic [tme_pkg::CODE_W-1:0]   dah_reg, dah_next;
    logic [tme_pkg::GAP_W-1:0]    gap_reg, gap_next;
    logic                         out_valid_reg, out_valid_next;
    logic                         key_reg, key_next;
    logic                         last_reg, last_next;

    logic advance;
    logic emit;
    logic unit_last;
    logic unit_key;

    // Output register frees when empty or taken
    assign advance   = !out_valid_reg || unit_out.ready;
    assign emit      = busy_reg && advance;
    assign unit_last = (phase_reg == PH_GAP) && (gap_reg == tme_pkg::GAP_W'(1));
    assign unit_key  = (phase_reg == PH_ON);
    assign q_pop     = q_valid && (!busy_reg || (emit && unit_last));

    assign unit_out.valid    = out_valid_reg;
    assign unit_out.key_on   = key_reg;
    assign unit_out.run_last = last_reg;

    // Sequence elements, separators and gap
    always_comb
    begin
        busy_next      = busy_reg;
        phase_next     = phase_reg;
        on_left_next   = on_left_reg;
        idx_next       = idx_reg;
        len_next       = len_reg;
        dah_next       = dah_reg;
        gap_next       = gap_reg;
        out_valid_next = out_valid_reg;
        key_next       = key_reg;
        last_next      = last_reg;

        // Drain the output register
        if (advance)
        begin
            out_valid_next = 1'b0;
        end

        // Step the current character
        if (emit)
        begin
            out_valid_next = 1'b1;
            key_next       = unit_key;
            last_next      = unit_last;
            case (phase_reg)
                PH_ON:
                begin
                    on_left_next = on_left_reg - 1'b1;
                    if (on_left_reg == tme_pkg::ON_W'(1))
                    begin
                        if (idx_reg == len_reg - 1'b1)
                        begin
                            phase_next = PH_GAP;
                        end
                        else
                        begin
                            phase_next = PH_SEP;
                            idx_next   = idx_reg + 1'b1;
                            dah_next   = dah_reg << 1;
                        end
                    end
                end
                PH_SEP:
                begin
                    phase_next   = PH_ON;
                    on_left_next = dah_reg[tme_pkg::CODE_W-1]
                                   ? tme_pkg::ON_W'(tme_pkg::DAH_UNITS)
                                   : tme_pkg::ON_W'(tme_pkg::DIT_UNITS);
                end
                PH_GAP:
                begin
                    gap_next = gap_reg - 1'b1;
                    if (unit_last)
                    begin
                        busy_next = 1'b0;
                    end
                end
                default:
                begin
                    phase_next = PH_GAP;
                end
            endcase
        end

        // Load the next character
        if (q_pop)
        begin
            busy_next    = 1'b1;
            len_next     = q_desc.len;
            dah_next     = q_desc.dah;
            gap_next     = q_desc.gap;
            idx_next     = '0;
            on_left_next = q_desc.dah[tme_pkg::CODE_W-1]
                           ? tme_pkg::ON_W'(tme_pkg::DAH_UNITS)
                           : tme_pkg::ON_W'(tme_pkg::DIT_UNITS);
            phase_next   = (q_desc.len != '0) ? PH_ON : PH_GAP;
        end
    end

    // Hold sequencer state and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            phase_reg     <= PH_GAP;
            on_left_reg   <= '0;
            idx_reg       <= '0;
            len_reg       <= '0;
            dah_reg       <= '0;
            gap_reg       <= '0;
            out_valid_reg <= 1'b0;
            key_reg       <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            phase_reg     <= phase_next;
            on_left_reg   <= on_left_next;
            idx_reg       <= idx_next;
            len_reg       <= len_next;
            dah_reg       <= dah_next;
            gap_reg       <= gap_next;
            out_valid_reg <= out_valid_next;
            key_reg       <= key_next;
            last_reg      <= last_next;
        end
    end

    a_last_is_off: assert property (@(posedge clk) disable iff (!rst_n)
        (unit_out.valid && unit_out.run_last) |-> !unit_out.key_on)
        else $error("final unit of a character is key down");

    a_gap_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && phase_reg == PH_GAP) |-> (gap_reg != '0))
        else $error("gap counter empty while in gap");

    a_on_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && phase_reg == PH_ON) |-> (on_left_reg != '0))
        else $error("on counter empty while key down");

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && phase_reg != PH_GAP) |-> (idx_reg < len_reg))
        else $error("element index beyond pattern length");

endmodule

/* rtl/text_to_morse_unit_encoder.sv */
// Text-to-Morse unit encoder, top level.
// Channels: char_in takes one ASCII byte per transaction (char_code) with
//   message_end set on the last character of a message; unit_out gives one
//   Morse timing unit per transaction (key_on: 1 key down, 0 key up) with
//   run_last set on the last unit of each character.
// Timing: dit is one on unit, dah three, one off unit between elements,
//   three off units after each character and four more after the last one.
//   Space gives one off unit before the gap; unknown bytes give only the gap.
// Path: the first unit of a character passes through the descriptor queue,
//   the sequencer state and the output register before it is valid.
// Throughput: one unit per cycle while unit_out takes units and descriptors
//   are queued; the back-end unit sequencer loads the next character as it
//   emits the previous one's last unit. A two-entry descriptor queue
//   sits between front and back, so char_in keeps accepting while units
//   of earlier characters are still playing.
// Stall: when unit_out.ready is low the output register holds, the
//   sequencer stops, and char_in.ready drops once the queue is full.
// Reset: rst_n (asynchronous, active low) empties the queue and drops
//   any character in progress.
// Depends on tme_pkg, tme_if, tme_front, tme_queue, tme_back.

module text_to_morse_unit_encoder (
    input  logic       clk,
    input  logic       rst_n,
    tme_char_if.sink   char_in,
    tme_unit_if.source unit_out
);

    logic               q_full;
    logic               q_push;
    logic               q_pop;
    logic               q_valid;
    tme_pkg::tme_desc_t q_din;
    tme_pkg::tme_desc_t q_dout;

    // Classify incoming characters
    tme_front u_front (
        .char_in (char_in),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_desc  (q_din)
    );

    // Decouple front and back
    tme_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .full  (q_full),
        .pop   (q_pop),
        .valid (q_valid),
        .dout  (q_dout)
    );

    // Play descriptors out as key units
    tme_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_desc   (q_dout),
        .q_pop    (q_pop),
        .unit_out (unit_out)
    );

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking bench for the text-to-Morse unit encoder: a directed and a
// random character stream, with results predicted and compared per unit.
// Depends on tme_pkg, tme_if and the text_to_morse_unit_encoder RTL.

module tb_top;

    typedef struct packed {
        logic key_on;
        logic run_last;
    } key_unit_t;

    typedef struct {
        logic [tme_pkg::CHAR_W-1:0] ch;
        logic                       last;
        bit                         drain;   // hold until every expected unit has come
    } char_item_t;

    localparam int ITEM_COUNT = 170;
    localparam int TAIL_CYCLES = 30;
    localparam int DRAIN_LIMIT = 5000;

    logic clk;
    logic rst_n;

    tme_char_if char_ch ();
    tme_unit_if unit_ch ();

    text_to_morse_unit_encoder uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .char_in  (char_ch),
        .unit_out (unit_ch)
    );

    char_item_t pending_chars[$];
    key_unit_t  exp_units[$];
    int         error_count = 0;
    int         send_hold = 0;
    int         sink_hold = 0;
    bit         send_quiet = 0;
    bit         sink_quiet = 0;

    // Every encodable character, space included
    string symbol_set = "abcdefghijklmnopqrstuvwxyz0123456789.,?'!/()&:;=+-_\"$@ ";

    // Dot-dash pattern of a character; empty when the byte has no code
    function automatic string morse_pattern(input logic [tme_pkg::CHAR_W-1:0] ch);
        case (ch)
            "a": return ".-";       "b": return "-...";     "c": return "-.-.";
            "d": return "-..";      "e": return ".";        "f": return "..-.";
            "g": return "--.";      "h": return "....";     "i": return "..";
            "j": return ".---";     "k": return "-.-";      "l": return ".-..";
            "m": return "--";       "n": return "-.";       "o": return "---";
            "p": return ".--.";     "q": return "--.-";     "r": return ".-.";
            "s": return "...";      "t": return "-";        "u": return "..-";
            "v": return "...-";     "w": return ".--";      "x": return "-..-";
            "y": return "-.--";     "z": return "--..";
            "0": return "-----";    "1": return ".----";    "2": return "..---";
            "3": return "...--";    "4": return "....-";    "5": return ".....";
            "6": return "-....";    "7": return "--...";    "8": return "---..";
            "9": return "----.";
            ".": return ".-.-.-";   ",": return "--..--";   "?": return "..--..";
            "'": return ".----.";   "!": return "-.-.--";   "/": return "-..-.";
            "(": return "-.--.";    ")": return "-.--.-";   "&": return ".-...";
            ":": return "---...";   ";": return "-.-.-.";   "=": return "-...-";
            "+": return ".-.-.";    "-": return "-....-";   "_": return "..--.-";
            "\"": return ".-..-.";  "$": return "...-..-";  "@": return ".--.-.";
            default: return "";
        endcase
    endfunction

    // Expand one character into its key units and queue them
    function automatic void encode_units(input logic [tme_pkg::CHAR_W-1:0] ch,
                                         input logic last);
        string     pat;
        bit        keys[$];
        key_unit_t u;
        pat = morse_pattern(ch);
        if (ch == tme_pkg::ASCII_SPACE)
            keys.insert(keys.size(), 1'b0);
        for (int e = 0; e < pat.len(); e++)
        begin
            if (e > 0)
                keys.insert(keys.size(), 1'b0);
            keys.insert(keys.size(), 1'b1);
            if (pat[e] == "-")
            begin
                keys.insert(keys.size(), 1'b1);
                keys.insert(keys.size(), 1'b1);
            end
        end
        repeat (tme_pkg::CHAR_GAP_UNITS) keys.insert(keys.size(), 1'b0);
        if (last)
            repeat (tme_pkg::END_GAP_UNITS) keys.insert(keys.size(), 1'b0);
        foreach (keys[i])
        begin
            u.key_on   = keys[i];
            u.run_last = (i == keys.size() - 1);
            exp_units.insert(exp_units.size(), u);
        end
    endfunction

    // Print one mismatch line and count it
    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        error_count++;
    endtask

    task automatic add_char(input logic [tme_pkg::CHAR_W-1:0] ch, input logic last,
                            input bit drain);
        char_item_t it;
        it.ch    = ch;
        it.last  = last;
        it.drain = drain;
        pending_chars.insert(pending_chars.size(), it);
    endtask

    // Idle cycles before the next transaction; quiet stretches have none
    function automatic int draw_send_gap();
        if ($urandom_range(0, 15) == 0)
            send_quiet = !send_quiet;
        return send_quiet ? 0 : $urandom_range(0, 10);
    endfunction

    function automatic int draw_sink_gap();
        if ($urandom_range(0, 15) == 0)
            sink_quiet = !sink_quiet;
        return sink_quiet ? 0 : $urandom_range(0, 10);
    endfunction

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Driver: present pending characters, honoring gaps and drain requests
    always @(posedge clk or negedge rst_n)
    begin
        char_item_t it;
        if (!rst_n)
        begin
            char_ch.valid       <= 1'b0;
            char_ch.char_code   <= '0;
            char_ch.message_end <= 1'b0;
            send_hold = 0;
        end
        else if (!char_ch.valid || char_ch.ready)
        begin
            if (char_ch.valid)
                send_hold = draw_send_gap();
            if (send_hold > 0)
            begin
                send_hold--;
                char_ch.valid <= 1'b0;
            end
            else if (pending_chars.size() > 0 &&
                     !(pending_chars[0].drain &&
                       (exp_units.size() != 0 || char_ch.valid)))
            begin
                it = pending_chars.pop_front();
                char_ch.valid       <= 1'b1;
                char_ch.char_code   <= it.ch;
                char_ch.message_end <= it.last;
            end
            else
                char_ch.valid <= 1'b0;
        end
    end

    // Sink: stall a random number of cycles after each unit
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_ch.ready <= 1'b0;
            sink_hold = 0;
        end
        else if (unit_ch.ready)
        begin
            if (unit_ch.valid)
            begin
                sink_hold = draw_sink_gap();
                if (sink_hold > 0)
                    unit_ch.ready <= 1'b0;
            end
        end
        else
        begin
            if (sink_hold > 0)
                sink_hold--;
            if (sink_hold == 0)
                unit_ch.ready <= 1'b1;
        end
    end

    // Monitor: predict on accepted characters, check accepted units
    always @(posedge clk)
    begin
        key_unit_t want;
        if (rst_n)
        begin
            if (char_ch.valid && char_ch.ready)
                encode_units(char_ch.char_code, char_ch.message_end);
            if (unit_ch.valid && unit_ch.ready)
            begin
                if (exp_units.size() == 0)
                begin
                    report_mismatch($sformatf("unit with no expectation (key_on %0b, run_last %0b)",
                                              unit_ch.key_on, unit_ch.run_last));
                end
                else
                begin
                    want = exp_units.pop_front();
                    if (unit_ch.key_on !== want.key_on)
                        report_mismatch($sformatf("key_on got %0d, expected %0d",
                                                  unit_ch.key_on, want.key_on));
                    if (unit_ch.run_last !== want.run_last)
                        report_mismatch($sformatf("run_last got %0d, expected %0d",
                                                  unit_ch.run_last, want.run_last));
                end
            end
        end
    end

    // Stimulus and end of run
    initial
    begin
        int    msg_len;
        int    wait_cycles;
        logic [tme_pkg::CHAR_W-1:0] ch;
        rst_n = 1'b0;

        // Directed: extremes, space, unknown bytes, longest patterns
        add_char("e", 1'b0, 1'b0);
        add_char("t", 1'b0, 1'b0);
        add_char(tme_pkg::ASCII_SPACE, 1'b0, 1'b0);
        add_char("$", 1'b0, 1'b0);
        add_char("0", 1'b1, 1'b0);
        add_char(8'h00, 1'b0, 1'b0);
        add_char(8'hff, 1'b1, 1'b0);
        add_char("A", 1'b0, 1'b0);
        add_char(8'h80, 1'b0, 1'b0);
        add_char(8'h7f, 1'b0, 1'b0);
        add_char("\"", 1'b0, 1'b0);
        add_char("@", 1'b0, 1'b0);
        add_char(tme_pkg::ASCII_SPACE, 1'b1, 1'b0);
        add_char("$", 1'b1, 1'b0);
        add_char("s", 1'b0, 1'b1);
        add_char("o", 1'b0, 1'b0);
        add_char("s", 1'b1, 1'b0);
        add_char("Z", 1'b1, 1'b0);
        add_char("9", 1'b0, 1'b0);
        add_char(")", 1'b1, 1'b0);

        // Random: short messages, mostly encodable text with some raw bytes
        while (pending_chars.size() < ITEM_COUNT)
        begin
            msg_len = $urandom_range(1, 8);
            for (int i = 0; i < msg_len; i++)
            begin
                if ($urandom_range(0, 99) < 85)
                    ch = symbol_set[$urandom_range(0, symbol_set.len() - 1)];
                else
                    ch = tme_pkg::CHAR_W'($urandom_range(0, 255));
                add_char(ch, i == msg_len - 1,
                         pending_chars.size() == ITEM_COUNT / 2);
            end
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every character to be taken, then for the units to drain
        while (pending_chars.size() > 0 || char_ch.valid)
            @(posedge clk);
        wait_cycles = 0;
        while (exp_units.size() > 0 && wait_cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (exp_units.size() != 0)
            report_mismatch($sformatf("%0d expected units never arrived", exp_units.size()));

        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5ms;
        $display("timeout");
        $display("*** FAILED ***");
        $finish;
    end

endmodule

/* text_to_morse_unit_encoder.f */
rtl/tme_pkg.sv
rtl/tme_if.sv
rtl/tme_front.sv
rtl/tme_queue.sv
rtl/tme_back.sv
rtl/text_to_morse_unit_encoder.sv
bench/tb_top.sv
